@@ rtl/core/lap9p_pkg.sv @@
`default_nettype none

package lap9p_pkg;

  // Grid geometry and number format
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int DIM_W   = 7;
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;

  // Stencil sum: weights total 40 in magnitude, so six guard bits
  localparam int ACC_W   = VALUE_BITS + 6;
  // Coefficient halves: low half unsigned, high half signed
  localparam int COEF_LO_W = FRAC_BITS;
  localparam int COEF_HI_W = VALUE_BITS - FRAC_BITS;
  localparam int PROD_W    = ACC_W + COEF_LO_W + 1;
  localparam int PART_W    = PROD_W - FRAC_BITS;
  localparam int Q_W       = PROD_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SAT   = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS   = 2'd0,
    CFG_GRID_COLS   = 2'd1,
    CFG_COEFF_SIXTH = 2'd2
  } cfg_idx_t;

  localparam logic [DIM_W-1:0]             ROWS_RESET  = 7'd64;
  localparam logic [DIM_W-1:0]             COLS_RESET  = 7'd64;
  localparam logic signed [VALUE_BITS-1:0] COEFF_RESET = 32'sd10923;

  typedef struct packed {
    op_t                           op;
    logic [ROW_W-1:0]              row;
    logic [COL_W-1:0]              col;
    logic signed [VALUE_BITS-1:0]  cell_value;
  } in_req_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  laplacian_value;
    status_t                       status;
  } out_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/laplacian_9pt_periodic_core.sv @@
`default_nettype none

// Nine-point isotropic Laplacian on a periodic grid held in a 4096 x 32 memory.
//
// Request channel: present in_req with start high; the request is taken at a
// rising edge where start is high and busy is low. A write request stores one
// cell in that cycle and gives no result; busy stays low, so one write can be
// taken every cycle. A query request reads the nine stencil cells one after
// another through the single memory port, then forms coeff * sum in two
// half-width multiply steps and saturates.
// Result channel: out_valid is high for exactly one cycle with out_rsp; the
// receiver cannot stall and must take it then.
// Timing: a query runs the nine serial memory reads, a drain step, the low and
// high multiply steps and a finishing step; busy drops as its result appears,
// so queries do not overlap. A query outside the grid in use gives its result
// in the next cycle and leaves busy low.
// Configuration: cfg_we/cfg_index/cfg_wdata write grid_rows, grid_cols and
// coeff_sixth; write only while the block is idle.
// Reset (rst_n low, synchronous) returns the control to idle and the
// registers to 64, 64 and 10923; the grid memory is not cleared, so a cell
// must be written before any query reads it.

module laplacian_9pt_periodic_core
  import lap9p_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_req_t               in_req,
  output logic                       out_valid,
  output out_rsp_t                   out_rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_MUL_LO,
    S_MUL_HI,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    TAP_C,
    TAP_XU,
    TAP_XD,
    TAP_YU,
    TAP_YD,
    TAP_XU_YU,
    TAP_XU_YD,
    TAP_XD_YU,
    TAP_XD_YD
  } tap_t;

  localparam logic signed [Q_W-1:0] Q_MAX = {{(Q_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {{(Q_W-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  state_t                       state_r;
  logic [DIM_W-1:0]             grid_rows_r;
  logic [DIM_W-1:0]             grid_cols_r;
  logic signed [VALUE_BITS-1:0] coeff_r;

  logic [ROW_W-1:0]             x_r, xu_r, xd_r;
  logic [COL_W-1:0]             y_r, yu_r, yd_r;
  tap_t                         cnt_r;
  tap_t                         tap_r;
  logic                         tap_vld_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic signed [PART_W-1:0]     part_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic                         out_valid_r;
  out_rsp_t                     out_rsp_r;

  logic [VALUE_BITS-1:0]        grid_mem [DEPTH];
  logic [VALUE_BITS-1:0]        rd_data_r;

  logic [DIM_W-1:0]             rows_use, cols_use;
  logic [DIM_W-1:0]             row_p1, col_p1, rows_m1, cols_m1;
  logic [ROW_W-1:0]             xu_new, xd_new;
  logic [COL_W-1:0]             yu_new, yd_new;
  logic                         accept, is_query, oor;
  logic [ADDR_W-1:0]            rd_addr;
  logic signed [ACC_W-1:0]      cell_ext, tap_term;
  logic signed [COEF_LO_W:0]    mul_b;
  logic signed [PROD_W-1:0]     product;
  logic signed [Q_W-1:0]        q_sum;
  logic                         sat_hi, sat_lo;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign accept   = start && !busy;
  assign is_query = (in_req.op == OP_QUERY);

  // Clamp grid size into 1..MAX
  always_comb begin
    if (grid_rows_r == '0) begin
      rows_use = DIM_W'(1);
    end else if (grid_rows_r > DIM_W'(MAX_ROWS)) begin
      rows_use = DIM_W'(MAX_ROWS);
    end else begin
      rows_use = grid_rows_r;
    end
    if (grid_cols_r == '0) begin
      cols_use = DIM_W'(1);
    end else if (grid_cols_r > DIM_W'(MAX_COLS)) begin
      cols_use = DIM_W'(MAX_COLS);
    end else begin
      cols_use = grid_cols_r;
    end
  end

  // Range check and periodic neighbours of the requested cell
  assign oor     = ({1'b0, in_req.row} >= rows_use) || ({1'b0, in_req.col} >= cols_use);
  assign row_p1  = {1'b0, in_req.row} + DIM_W'(1);
  assign col_p1  = {1'b0, in_req.col} + DIM_W'(1);
  assign rows_m1 = rows_use - DIM_W'(1);
  assign cols_m1 = cols_use - DIM_W'(1);
  assign xu_new  = (row_p1 == rows_use) ? '0 : row_p1[ROW_W-1:0];
  assign yu_new  = (col_p1 == cols_use) ? '0 : col_p1[COL_W-1:0];
  assign xd_new  = (in_req.row == '0) ? rows_m1[ROW_W-1:0] : in_req.row - ROW_W'(1);
  assign yd_new  = (in_req.col == '0) ? cols_m1[COL_W-1:0] : in_req.col - COL_W'(1);

  // Select the stencil cell for this read slot
  always_comb begin
    case (cnt_r)
      TAP_C:     rd_addr = {x_r,  y_r};
      TAP_XU:    rd_addr = {xu_r, y_r};
      TAP_XD:    rd_addr = {xd_r, y_r};
      TAP_YU:    rd_addr = {x_r,  yu_r};
      TAP_YD:    rd_addr = {x_r,  yd_r};
      TAP_XU_YU: rd_addr = {xu_r, yu_r};
      TAP_XU_YD: rd_addr = {xu_r, yd_r};
      TAP_XD_YU: rd_addr = {xd_r, yu_r};
      TAP_XD_YD: rd_addr = {xd_r, yd_r};
      default:   rd_addr = {x_r,  y_r};
    endcase
  end

  // Weight the returned cell: the centre by -20, each edge by 4 and each corner by 1
  assign cell_ext = ACC_W'($signed(rd_data_r));
  always_comb begin
    case (tap_r)
      TAP_C:   tap_term = -((cell_ext <<< 4) + (cell_ext <<< 2));
      TAP_XU,
      TAP_XD,
      TAP_YU,
      TAP_YD:  tap_term = cell_ext <<< 2;
      default: tap_term = cell_ext;
    endcase
  end

  // Shared multiplier: low coefficient half first, then the signed high half
  assign mul_b   = (state_r == S_MUL_LO) ? $signed({1'b0, coeff_r[COEF_LO_W-1:0]})
                                         : (COEF_LO_W+1)'(
                                             $signed(coeff_r[VALUE_BITS-1:COEF_LO_W]));
  assign product = acc_r * mul_b;

  // Recombine halves; the low half is already floored by the fraction shift
  assign q_sum  = Q_W'(prod_r) + Q_W'(part_r);
  assign sat_hi = (q_sum > Q_MAX);
  assign sat_lo = (q_sum < Q_MIN);

  // Grid memory: one port, write on a write request, read during the scan
  always_ff @(posedge clk) begin
    if (accept && !is_query) begin
      grid_mem[{in_req.row, in_req.col}] <= in_req.cell_value;
    end
    if (state_r == S_READ) begin
      rd_data_r <= grid_mem[rd_addr];
    end
  end

  // Control, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grid_rows_r <= ROWS_RESET;
      grid_cols_r <= COLS_RESET;
      coeff_r     <= COEFF_RESET;
      cnt_r       <= TAP_C;
      tap_r       <= TAP_C;
      tap_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      tap_vld_r   <= (state_r == S_READ);
      tap_r       <= cnt_r;

      // Take configuration writes; unknown indexes drop
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_GRID_ROWS:   grid_rows_r <= cfg_wdata[DIM_W-1:0];
          CFG_GRID_COLS:   grid_cols_r <= cfg_wdata[DIM_W-1:0];
          CFG_COEFF_SIXTH: coeff_r     <= $signed(cfg_wdata[VALUE_BITS-1:0]);
          default:         ;
        endcase
      end

      // Accumulate each weighted cell in the cycle after its read
      if (tap_vld_r) begin
        acc_r <= acc_r + tap_term;
      end

      case (state_r)
        S_IDLE: begin
          if (accept && is_query) begin
            if (oor) begin
              out_valid_r                <= 1'b1;
              out_rsp_r.laplacian_value  <= '0;
              out_rsp_r.status           <= STAT_RANGE;
            end else begin
              x_r     <= in_req.row;
              y_r     <= in_req.col;
              xu_r    <= xu_new;
              xd_r    <= xd_new;
              yu_r    <= yu_new;
              yd_r    <= yd_new;
              acc_r   <= '0;
              cnt_r   <= TAP_C;
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          if (cnt_r == TAP_XD_YD) begin
            cnt_r   <= TAP_C;
            state_r <= S_DRAIN;
          end else begin
            cnt_r   <= tap_t'(cnt_r + 4'd1);
          end
        end
        S_DRAIN: begin
          state_r <= S_MUL_LO;
        end
        S_MUL_LO: begin
          part_r  <= product[PROD_W-1:FRAC_BITS];
          state_r <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_r  <= product;
          state_r <= S_FIN;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          if (sat_hi) begin
            out_rsp_r.laplacian_value <= V_MAX;
            out_rsp_r.status          <= STAT_SAT;
          end else if (sat_lo) begin
            out_rsp_r.laplacian_value <= V_MIN;
            out_rsp_r.status          <= STAT_SAT;
          end else begin
            out_rsp_r.laplacian_value <= q_sum[VALUE_BITS-1:0];
            out_rsp_r.status          <= STAT_OK;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // A result comes only from the final step or from an out-of-grid query
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_FIN) || $past(accept && is_query && oor))
    else $error("result strobe without a finishing query");

  // Weighted cells are only summed during the scan and its drain cycle
  a_tap_window: assert property (@(posedge clk) disable iff (!rst_n)
    tap_vld_r |-> (state_r == S_READ) || (state_r == S_DRAIN))
    else $error("stencil tap outside the scan window");

  // An in-grid query holds off further requests
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_query && !oor) |=> busy)
    else $error("query accepted without raising busy");

  // A saturated result carries one of the two bounds
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.status == STAT_SAT) |->
      (out_rsp_r.laplacian_value == V_MAX) || (out_rsp_r.laplacian_value == V_MIN))
    else $error("saturated result not at a bound");

  // An out-of-grid result is zero
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.status == STAT_RANGE) |-> (out_rsp_r.laplacian_value == '0))
    else $error("out-of-grid result not zero");

endmodule

`default_nettype wire

@@ dv/tb_laplacian_9pt_periodic_core.sv @@
`timescale 1ns / 100ps

module tb_laplacian_9pt_periodic_core;
  import lap9p_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 100;
  localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
  localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  start;
  logic                  busy;
  in_req_t               in_req;
  logic                  out_valid;
  out_rsp_t              out_rsp;

  laplacian_9pt_periodic_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  // Shadow of the block: grid contents, written flags and registers
  logic signed [VALUE_BITS-1:0] grid_copy [DEPTH];
  bit                           cell_written [DEPTH];
  logic [DIM_W-1:0]             rows_cfg;
  logic [DIM_W-1:0]             cols_cfg;
  logic signed [VALUE_BITS-1:0] coeff_cfg;

  out_rsp_t lap_expected [$];
  out_rsp_t want;
  bit       gaps_on;
  int       fail_count;
  int       req_count;
  int       query_count;
  int       range_count;
  int       sat_count;
  int       result_count;
  int       cfg_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_dim(logic [DIM_W-1:0] v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : int'(v);
  endfunction

  // Tap k: k = 0 is the centre, k = 1 to 4 the edge neighbours, k = 5 to 8 the corners
  function automatic int tap_weight(int k);
    if (k == 0) return -20;
    return (k < 5) ? 4 : 1;
  endfunction

  function automatic int stencil_addr(logic [ROW_W-1:0] row, logic [COL_W-1:0] col, int k);
    int rows, cols, dr, dc, r, c;
    rows = eff_dim(rows_cfg, MAX_ROWS);
    cols = eff_dim(cols_cfg, MAX_COLS);
    dr = (k == 1 || k == 5 || k == 6) ? 1 : (k == 2 || k == 7 || k == 8) ? -1 : 0;
    dc = (k == 3 || k == 5 || k == 7) ? 1 : (k == 4 || k == 6 || k == 8) ? -1 : 0;
    r = (int'(row) + dr + rows) % rows;
    c = (int'(col) + dc + cols) % cols;
    return r * MAX_COLS + c;
  endfunction

  // Scaled stencil: floor(coeff * sum / 2^FRAC_BITS), saturated
  function automatic out_rsp_t predict_laplacian(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    out_rsp_t res;
    longint acc;
    logic signed [71:0] wide_sum, wide_coef, prod, q;
    res.laplacian_value = '0;
    res.status = STAT_OK;
    if (row >= eff_dim(rows_cfg, MAX_ROWS) || col >= eff_dim(cols_cfg, MAX_COLS)) begin
      res.status = STAT_RANGE;
      return res;
    end
    acc = 0;
    for (int k = 0; k < 9; k++)
      acc += longint'(tap_weight(k)) * longint'(grid_copy[stencil_addr(row, col, k)]);
    wide_sum = 72'(acc);
    wide_coef = 72'(coeff_cfg);
    prod = wide_sum * wide_coef;
    q = prod >>> FRAC_BITS;
    if (q > SAT_HI) begin
      res.laplacian_value = SAT_HI[VALUE_BITS-1:0];
      res.status = STAT_SAT;
    end else if (q < SAT_LO) begin
      res.laplacian_value = SAT_LO[VALUE_BITS-1:0];
      res.status = STAT_SAT;
    end else begin
      res.laplacian_value = q[VALUE_BITS-1:0];
    end
    return res;
  endfunction

  // Update the shadow for a request taken at this edge
  function automatic void apply_request(in_req_t req);
    int addr;
    out_rsp_t res;
    addr = int'(req.row) * MAX_COLS + int'(req.col);
    req_count++;
    if (req.op == OP_WRITE) begin
      grid_copy[addr] = req.cell_value;
      cell_written[addr] = 1'b1;
    end else begin
      res = predict_laplacian(req.row, req.col);
      query_count++;
      if (res.status == STAT_RANGE) range_count++;
      if (res.status == STAT_SAT) sat_count++;
      lap_expected.push_back(res);
    end
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $urandom;
      3:       return '0;
      default: return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0, 1, 2: return 7'($urandom_range(1, 8));
      3:       return '0;
      4:       return 7'd64;
      5:       return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coeff();
    case ($urandom_range(0, 5))
      0:       return COEFF_RESET;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return $urandom;
      default: return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
    endcase
  endfunction

  // Present one request and hold it until taken
  task automatic send_req(input in_req_t req);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    apply_request(req);
  endtask

  task automatic write_cell(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic signed [VALUE_BITS-1:0] value);
    in_req_t req;
    req.op = OP_WRITE;
    req.row = row;
    req.col = col;
    req.cell_value = value;
    send_req(req);
  endtask

  // For an in-grid cell, write any unwritten stencil cell first; then query
  task automatic query_cell(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    in_req_t req;
    int addr;
    if (row < eff_dim(rows_cfg, MAX_ROWS) && col < eff_dim(cols_cfg, MAX_COLS)) begin
      for (int k = 0; k < 9; k++) begin
        addr = stencil_addr(row, col, k);
        if (!cell_written[addr])
          write_cell(ROW_W'(addr / MAX_COLS), COL_W'(addr % MAX_COLS), rand_value());
      end
    end
    req.op = OP_QUERY;
    req.row = row;
    req.col = col;
    req.cell_value = $urandom;
    send_req(req);
  endtask

  // Drop start, wait for every result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (lap_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    start     <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_ROWS:   rows_cfg = data[DIM_W-1:0];
      CFG_GRID_COLS:   cols_cfg = data[DIM_W-1:0];
      CFG_COEFF_SIXTH: coeff_cfg = data[VALUE_BITS-1:0];
      default: ;
    endcase
    cfg_count++;
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      result_count++;
      if (lap_expected.size() == 0) begin
        $error("result with no query outstanding: laplacian_value %0d status %0d",
               out_rsp.laplacian_value, out_rsp.status);
        fail_count++;
      end else begin
        want = lap_expected.pop_front();
        if (out_rsp.laplacian_value !== want.laplacian_value) begin
          $error("laplacian_value: expected %0d, got %0d",
                 want.laplacian_value, out_rsp.laplacian_value);
          fail_count++;
        end
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_rsp.status);
          fail_count++;
        end
      end
    end
  end

  // Stop the run if nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || cfg_we || (start && !busy) || out_valid) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) break;
    end
    $display("Timeout: nothing taken or returned for %0d cycles", STALL_LIMIT);
    $display("FAIL laplacian_9pt_periodic_core");
    $finish;
  end

  // Default 64x64 grid: extremes around the corner so the stencil wraps across both edges
  task automatic test_corner_wrap();
    write_cell(0, 0, 32'sh8000_0000);
    write_cell(1, 0, 32'sh7FFF_FFFF);
    write_cell(63, 0, 32'sh7FFF_FFFF);
    write_cell(0, 1, 32'sh7FFF_FFFF);
    write_cell(0, 63, 32'sh7FFF_FFFF);
    write_cell(1, 1, 32'sh7FFF_FFFF);
    write_cell(1, 63, 32'sh7FFF_FFFF);
    write_cell(63, 1, 32'sh7FFF_FFFF);
    write_cell(63, 63, 32'sh7FFF_FFFF);
    query_cell(0, 0);
    query_cell(63, 63);
    query_cell(0, 63);
    settle();
  endtask

  // Zero and oversize dimensions, misses, and a write kept outside the grid
  task automatic test_grid_limits();
    set_reg(CFG_GRID_ROWS, '0);
    set_reg(CFG_GRID_COLS, '0);
    query_cell(0, 0);
    query_cell(0, 1);
    query_cell(1, 0);
    query_cell(63, 63);
    write_cell(2, 3, 32'sh0012_3456);
    settle();
    set_reg(CFG_GRID_ROWS, 32'hFFFF_FF7F);
    set_reg(CFG_GRID_COLS, 32'd65);
    query_cell(2, 3);
    settle();
    set_reg(CFG_GRID_ROWS, 32'd2);
    set_reg(CFG_GRID_COLS, 32'd1);
    query_cell(1, 0);
    query_cell(0, 1);
    settle();
  endtask

  // 3x3 grid of opposite extremes against each coefficient extreme, zero and small values
  task automatic test_coeff_limits();
    set_reg(CFG_GRID_ROWS, 32'd3);
    set_reg(CFG_GRID_COLS, 32'd3);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        write_cell(ROW_W'(r), COL_W'(c),
                   (r == 1 && c == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
    set_reg(CFG_COEFF_SIXTH, 32'h7FFF_FFFF);
    query_cell(1, 1);
    settle();
    set_reg(CFG_COEFF_SIXTH, 32'h8000_0000);
    query_cell(1, 1);
    settle();
    set_reg(CFG_COEFF_SIXTH, '0);
    query_cell(1, 1);
    settle();
    // Small coefficients of both signs exercise floor rounding
    set_reg(CFG_COEFF_SIXTH, 32'd1);
    query_cell(1, 1);
    query_cell(0, 2);
    settle();
    set_reg(CFG_COEFF_SIXTH, 32'hFFFF_FFFF);
    query_cell(1, 1);
    settle();
  endtask

  // Random settings, then mostly in-grid queries with some writes and stray coordinates
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] wd;
    int rows, cols, pick, phase_start;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wd = ($urandom_range(0, 1) == 0) ? '0 : CFG_DATA_W'($urandom);
      wd[DIM_W-1:0] = pick_dim();
      set_reg(CFG_GRID_ROWS, wd);
      wd = ($urandom_range(0, 1) == 0) ? '0 : CFG_DATA_W'($urandom);
      wd[DIM_W-1:0] = pick_dim();
      set_reg(CFG_GRID_COLS, wd);
      set_reg(CFG_COEFF_SIXTH, pick_coeff());
      rows = eff_dim(rows_cfg, MAX_ROWS);
      cols = eff_dim(cols_cfg, MAX_COLS);
      gaps_on = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      // Count stencil fill writes against the phase budget too
      phase_start = req_count;
      while (req_count - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 19);
        if (pick < 12)
          query_cell(ROW_W'($urandom_range(0, rows - 1)),
                     COL_W'($urandom_range(0, cols - 1)));
        else if (pick < 15)
          write_cell(ROW_W'($urandom_range(0, rows - 1)),
                     COL_W'($urandom_range(0, cols - 1)), rand_value());
        else if (pick < 17)
          write_cell(ROW_W'($urandom_range(0, 63)), COL_W'($urandom_range(0, 63)),
                     rand_value());
        else
          query_cell(ROW_W'($urandom_range(0, 63)), COL_W'($urandom_range(0, 63)));
      end
      settle();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_GRID_ROWS;
    cfg_wdata <= '0;
    start     <= 1'b0;
    in_req    <= '0;
    rows_cfg  = ROWS_RESET;
    cols_cfg  = COLS_RESET;
    coeff_cfg = COEFF_RESET;
    gaps_on   = 1'b1;
    fail_count = 0;
    req_count = 0;
    query_count = 0;
    range_count = 0;
    sat_count = 0;
    result_count = 0;
    cfg_count = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_corner_wrap();
    test_grid_limits();
    test_coeff_limits();
    test_random_traffic();

    $display("Run covered %0d requests, %0d of them queries, across %0d register writes",
             req_count, query_count, cfg_count);
    $display("Results checked: %0d (%0d saturated, %0d outside the grid)",
             result_count, sat_count, range_count);
    if (fail_count == 0)
      $display("PASS laplacian_9pt_periodic_core");
    else
      $display("FAIL laplacian_9pt_periodic_core");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/lap9p_pkg.sv
rtl/core/laplacian_9pt_periodic_core.sv
dv/tb_laplacian_9pt_periodic_core.sv
